### hdl/maq_pkg.sv
// Package: item types, function codes and register indexes of the adjacency query block.
package maq_pkg;

    localparam int VID_W = 20;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_FACES = 2'd1,
        FUNC_NBRS  = 2'd2,
        FUNC_EDGE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_FACE_COUNT = 2'd0,
        REG_CORNERS    = 2'd1
    } reg_index_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [11:0]      face_slot;
        logic [1:0]       corner;
        logic [VID_W-1:0] vertex_id;
        logic [VID_W-1:0] edge_end;
    } req_t;

    typedef struct packed {
        logic [VID_W-1:0] value;
        logic             none;
        logic             found;
        logic             overflow;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  reg_index;
        logic [12:0] wdata;
    } cfg_t;

endpackage

### hdl/maq_chan_if.sv
// Interface: valid/ready channel carrying one item of a given type.
interface maq_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/mesh_adjacency_query.sv
// Top level: face table in memory and a sequencer that runs the adjacency scans.
//
// Use: items arrive on req. A load (FUNC_LOAD) writes one corner of one face
// into the face memory in the cycle it is accepted and gives no result.
// Queries scan faces 0 .. face_count-1 (clamped to MAX_FACES) and corners
// 0 .. corners_per_face-1 (clamped to 3 .. MAX_DEGREE), reading each corner's
// face memory word (S_RD), testing it (S_EV) and stepping on (S_NEXT). A
// neighbour query also tests each face's closing edge, and looks up each
// neighbour found in the list memory, comparing stored entries one by one and
// appending it if not listed. Each memory has a single read port.
// Results leave on rsp; a query gives one item when its list is empty or for
// an edge query, else one item per list entry, the final one marked last.
// req is ready only between queries. The output register lets a finished
// query's last item wait while the next item is taken; if rsp stalls, the
// sequencer holds until the register frees.
// cfg writes face_count (index 0) and corners_per_face (index 1); it is always
// ready. The user must write cfg only while the block is idle; no logic checks it.
// Reset returns the sequencer to idle, clears the output valid and sets
// face_count to 0 and corners_per_face to 3. Face memory is undefined until
// loaded.
module mesh_adjacency_query
    import maq_pkg::*;
#(
    parameter int MAX_FACES  = 4096,
    parameter int MAX_DEGREE = 4,
    parameter int MAX_LIST   = 32
)
(
    input  logic  clk,
    input  logic  rst_n,
    maq_chan_if.sink   req,
    maq_chan_if.source rsp,
    maq_chan_if.sink   cfg
);

    localparam int FW  = $clog2(MAX_FACES + 1);
    localparam int FIW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int CW  = $clog2(MAX_DEGREE);
    localparam int AW  = $clog2(MAX_FACES * MAX_DEGREE);
    localparam int LW  = $clog2(MAX_LIST);
    localparam int NW  = $clog2(MAX_LIST + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_EV   = 8'b0000_0100,
        S_NEXT = 8'b0000_1000,
        S_SRCH = 8'b0001_0000,
        S_CMP  = 8'b0010_0000,
        S_EMIT = 8'b0100_0000,
        S_EOUT = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       func_reg, func_next;
    logic [11:0]      slot_reg, slot_next;
    logic [VID_W-1:0] vid_reg, vid_next;
    logic [VID_W-1:0] eend_reg, eend_next;
    logic [FW-1:0]    f_reg, f_next;
    logic [CW-1:0]    c_reg, c_next;
    logic [NW-1:0]    len_reg, len_next;
    logic [NW-1:0]    sidx_reg, sidx_next;
    logic [NW-1:0]    eidx_reg, eidx_next;
    logic             ovf_reg, ovf_next;
    logic             hs_reg, hs_next;
    logic             he_reg, he_next;
    logic             wrap_reg, wrap_next;
    logic             fnd_reg, fnd_next;
    logic [VID_W-1:0] first_reg, first_next;
    logic [VID_W-1:0] prev_reg, prev_next;
    logic [VID_W-1:0] nb_reg, nb_next;
    logic [VID_W-1:0] res_reg, res_next;
    logic [12:0]      fcount_reg;
    logic [2:0]       cpf_reg;
    logic             ovalid_reg, ovalid_next;
    rsp_t             odata_reg, odata_next;

    // Face memory and list memory
    logic [VID_W-1:0] face_mem [MAX_FACES * MAX_DEGREE];
    logic [VID_W-1:0] list_mem [MAX_LIST];
    logic             fm_we, lm_we;
    logic [AW-1:0]    fm_waddr, fm_raddr;
    logic [VID_W-1:0] fm_wdata, fm_rdata, lm_wdata, lm_rdata;
    logic [LW-1:0]    lm_waddr, lm_raddr;

    logic [FW-1:0]    nf;
    logic [3:0]       deg;
    logic             last_corner, last_face, out_free, req_fire;
    logic             e_hit;
    logic [VID_W-1:0] e_nb, e_s, e_e;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid = ovalid_reg;
    assign rsp.data  = odata_reg;
    assign out_free  = !ovalid_reg || rsp.ready;

    // Clamp the scan bounds
    always_comb
    begin
        if (32'(fcount_reg) > MAX_FACES)
            nf = FW'(MAX_FACES);
        else
            nf = FW'(fcount_reg);
        if (cpf_reg < 3'd3)
            deg = 4'd3;
        else if (32'(cpf_reg) > MAX_DEGREE)
            deg = 4'(MAX_DEGREE);
        else
            deg = 4'(cpf_reg);
    end

    assign last_corner = (4'(c_reg) == deg - 4'd1);
    assign last_face   = (f_reg + FW'(1) == nf);

    // Edge test: an edge touching the queried vertex yields its other end
    always_comb
    begin
        if (state_reg == S_NEXT)
        begin
            e_s = prev_reg;
            e_e = first_reg;
        end
        else
        begin
            e_s = prev_reg;
            e_e = fm_rdata;
        end
        e_hit = (e_s == vid_reg) || (e_e == vid_reg);
        e_nb  = (e_s == vid_reg) ? e_e : e_s;
    end

    always_ff @(posedge clk)
    begin
        if (fm_we)
            face_mem[fm_waddr] <= fm_wdata;
        fm_rdata <= face_mem[fm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lm_we)
            list_mem[lm_waddr] <= lm_wdata;
        lm_rdata <= list_mem[lm_raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        slot_next   = slot_reg;
        vid_next    = vid_reg;
        eend_next   = eend_reg;
        f_next      = f_reg;
        c_next      = c_reg;
        len_next    = len_reg;
        sidx_next   = sidx_reg;
        eidx_next   = eidx_reg;
        ovf_next    = ovf_reg;
        hs_next     = hs_reg;
        he_next     = he_reg;
        wrap_next   = wrap_reg;
        fnd_next    = fnd_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        nb_next     = nb_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        odata_next  = odata_reg;

        fm_we    = 1'b0;
        fm_waddr = AW'(req.data.face_slot) * AW'(MAX_DEGREE) + AW'(req.data.corner);
        fm_wdata = req.data.vertex_id;
        fm_raddr = AW'(f_reg[FIW-1:0]) * AW'(MAX_DEGREE) + AW'(c_reg);
        lm_we    = 1'b0;
        lm_waddr = len_reg[LW-1:0];
        lm_wdata = (func_reg == FUNC_FACES) ? VID_W'(f_reg) : nb_reg;
        // Hold the emit address while the output waits, so the read data stays
        lm_raddr = (state_reg == S_EMIT || state_reg == S_EOUT) ? eidx_reg[LW-1:0]
                                                               : sidx_reg[LW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.data.func == FUNC_LOAD)
                    begin
                        // Drop loads outside the table
                        fm_we = (32'(req.data.face_slot) < MAX_FACES) &&
                                (32'(req.data.corner) < MAX_DEGREE);
                    end
                    else
                    begin
                        func_next = req.data.func;
                        slot_next = req.data.face_slot;
                        vid_next  = req.data.vertex_id;
                        eend_next = req.data.edge_end;
                        res_next  = VID_W'(req.data.face_slot);
                        f_next    = '0;
                        c_next    = '0;
                        len_next  = '0;
                        eidx_next = '0;
                        ovf_next  = 1'b0;
                        hs_next   = 1'b0;
                        he_next   = 1'b0;
                        wrap_next = 1'b0;
                        fnd_next  = 1'b0;
                        state_next = (nf == '0) ? S_EMIT : S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                state_next = S_NEXT;
                case (func_reg)
                    FUNC_FACES:
                    begin
                        if (fm_rdata == vid_reg)
                        begin
                            if (32'(len_reg) < MAX_LIST)
                            begin
                                lm_we    = 1'b1;
                                len_next = len_reg + NW'(1);
                            end
                            else
                                ovf_next = 1'b1;
                        end
                    end
                    FUNC_NBRS:
                    begin
                        prev_next = fm_rdata;
                        if (c_reg == '0)
                            first_next = fm_rdata;
                        else if (e_hit)
                        begin
                            nb_next    = e_nb;
                            sidx_next  = '0;
                            state_next = S_SRCH;
                        end
                    end
                    default:
                    begin
                        if (fm_rdata == vid_reg)
                            hs_next = 1'b1;
                        if (fm_rdata == eend_reg)
                            he_next = 1'b1;
                    end
                endcase
            end
            S_NEXT:
            begin
                if (!last_corner)
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = S_RD;
                end
                else if (func_reg == FUNC_NBRS && !wrap_reg)
                begin
                    // Closing edge from the last corner back to the first
                    wrap_next = 1'b1;
                    if (e_hit)
                    begin
                        nb_next    = e_nb;
                        sidx_next  = '0;
                        state_next = S_SRCH;
                    end
                end
                else if (func_reg == FUNC_EDGE && hs_reg && he_reg &&
                         32'(f_reg) != 32'(slot_reg))
                begin
                    res_next   = VID_W'(f_reg);
                    fnd_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    hs_next    = 1'b0;
                    he_next    = 1'b0;
                    wrap_next  = 1'b0;
                    c_next     = '0;
                    f_next     = f_reg + FW'(1);
                    state_next = last_face ? S_EMIT : S_RD;
                end
            end
            S_SRCH:
            begin
                if (sidx_reg == len_reg)
                begin
                    // Not yet listed: append, or flag if full
                    if (32'(len_reg) < MAX_LIST)
                    begin
                        lm_we    = 1'b1;
                        len_next = len_reg + NW'(1);
                    end
                    else
                        ovf_next = 1'b1;
                    state_next = S_NEXT;
                end
                else
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                if (lm_rdata == nb_reg)
                    state_next = S_NEXT;
                else
                begin
                    sidx_next  = sidx_reg + NW'(1);
                    state_next = S_SRCH;
                end
            end
            S_EMIT:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (out_free)
                begin
                    ovalid_next        = 1'b1;
                    odata_next.found    = 1'b0;
                    odata_next.none     = 1'b0;
                    odata_next.overflow = ovf_reg;
                    odata_next.last     = 1'b1;
                    odata_next.value    = lm_rdata;
                    if (func_reg == FUNC_EDGE)
                    begin
                        odata_next.value    = res_reg;
                        odata_next.found    = fnd_reg;
                        odata_next.overflow = 1'b0;
                        state_next          = S_IDLE;
                    end
                    else if (len_reg == '0)
                    begin
                        odata_next.value = '0;
                        odata_next.none  = 1'b1;
                        state_next       = S_IDLE;
                    end
                    else if (eidx_reg + NW'(1) == len_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        odata_next.last = 1'b0;
                        eidx_next       = eidx_reg + NW'(1);
                        state_next      = S_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            fcount_reg <= '0;
            cpf_reg    <= 3'd3;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.data.reg_index == REG_FACE_COUNT)
                    fcount_reg <= cfg.data.wdata;
                else if (cfg.data.reg_index == REG_CORNERS)
                    cpf_reg <= cfg.data.wdata[2:0];
            end
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        slot_reg  <= slot_next;
        vid_reg   <= vid_next;
        eend_reg  <= eend_next;
        f_reg     <= f_next;
        c_reg     <= c_next;
        len_reg   <= len_next;
        sidx_reg  <= sidx_next;
        eidx_reg  <= eidx_next;
        ovf_reg   <= ovf_next;
        hs_reg    <= hs_next;
        he_reg    <= he_next;
        wrap_reg  <= wrap_next;
        fnd_reg   <= fnd_next;
        first_reg <= first_next;
        prev_reg  <= prev_next;
        nb_reg    <= nb_next;
        res_reg   <= res_next;
        odata_reg <= odata_next;
    end

endmodule
